@@ hdl/nps_pkg.sv @@
`timescale 1ns / 1ps
// Package for the non-preemptive priority scheduler.
// Field widths, the default table depth and the task table entry type.
// No dependencies.
package nps_pkg;

  localparam int unsigned MaxTasksDef = 16;

  localparam int unsigned IdW   = 8;
  localparam int unsigned ArrW  = 16;
  localparam int unsigned DurW  = 12;
  localparam int unsigned PrioW = 4;
  localparam int unsigned TimeW = 20;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [ArrW-1:0]  arrival;
    logic [DurW-1:0]  duration;
    logic [PrioW-1:0] prio;
  } entry_t;

endpackage

@@ hdl/nps_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces of the non-preemptive priority scheduler.
// Depends on nps_pkg for the field widths.
interface nps_in_if;
  logic                        valid;
  logic                        ready;
  logic [nps_pkg::IdW-1:0]     task_id;
  logic [nps_pkg::ArrW-1:0]    arrival_time;
  logic [nps_pkg::DurW-1:0]    duration;
  logic [nps_pkg::PrioW-1:0]   priority_req;
  logic                        last_task;

  modport source (output valid, task_id, arrival_time, duration, priority_req, last_task,
                  input ready);
  modport sink   (input valid, task_id, arrival_time, duration, priority_req, last_task,
                  output ready);
endinterface

interface nps_out_if;
  logic                        valid;
  logic                        ready;
  logic [nps_pkg::IdW-1:0]     sched_task_id;
  logic [nps_pkg::TimeW-1:0]   start_time;
  logic [nps_pkg::TimeW-1:0]   finish_time;
  logic [nps_pkg::TimeW-1:0]   wait_time;
  logic                        last_result;

  modport source (output valid, sched_task_id, start_time, finish_time, wait_time,
                  last_result, input ready);
  modport sink   (input valid, sched_task_id, start_time, finish_time, wait_time,
                  last_result, output ready);
endinterface

@@ hdl/nonpreemptive_priority_scheduler.sv @@
`timescale 1ns / 1ps
// Non-preemptive priority scheduler: task table, scan sequencer and result register.
// Depends on nps_pkg and the channel interfaces in nps_if.sv.
//
//   channel  | dir | beat                                         | accepted when
//   in_i     | in  | task_id, arrival_time, duration, priority_req, | valid && ready
//            |     | last_task                                     |
//   out_o    | out | sched_task_id, start_time, finish_time,       | valid && ready
//            |     | wait_time, last_result                        |
//
// After the beat marked last, each result costs one pass of the compare unit over the n
// loaded entries through the table's read port, and another pass when time must jump over
// an idle gap; output stalls can hold a result back further.
// Reset clears the control state and the result registers; the table contents are never cleared.
// No new load is taken until the last result of the set has been delivered.
module nonpreemptive_priority_scheduler #(
  parameter int unsigned MAX_TASKS = nps_pkg::MaxTasksDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nps_in_if.sink    in_i,
  nps_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(MAX_TASKS);
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_DECIDE,
    S_EMIT
  } state_e;

  state_e                        state_q;
  logic [CntW-1:0]               cnt_q;
  logic [CntW-1:0]               emit_q;
  logic [CntW-1:0]               scan_q;
  logic                          issue_q;
  logic                          rvld_q;
  logic [IdxW-1:0]               ridx_q;
  logic [MAX_TASKS-1:0]          done_q;
  logic [nps_pkg::TimeW-1:0]     cur_q;

  logic                          found_q;
  logic [IdxW-1:0]               best_idx_q;
  logic [nps_pkg::IdW-1:0]       best_id_q;
  logic [nps_pkg::ArrW-1:0]      best_arr_q;
  logic [nps_pkg::DurW-1:0]      best_dur_q;
  logic [nps_pkg::PrioW-1:0]     best_prio_q;
  logic [nps_pkg::ArrW-1:0]      earliest_q;

  logic [nps_pkg::IdW-1:0]       out_id_q;
  logic [nps_pkg::TimeW-1:0]     out_start_q;
  logic [nps_pkg::TimeW-1:0]     out_finish_q;
  logic [nps_pkg::TimeW-1:0]     out_wait_q;
  logic                          out_last_q;

  nps_pkg::entry_t               mem [MAX_TASKS];
  nps_pkg::entry_t               rd_q;
  nps_pkg::entry_t               wr_entry;

  logic                          in_acc;
  logic                          wr_en;
  logic [CntW-1:0]               n_last;
  logic                          pending;
  logic                          is_ready;
  logic                          take;
  logic                          scan_end;
  logic [nps_pkg::TimeW-1:0]     finish;

  assign in_acc   = in_i.valid && in_i.ready;
  assign wr_en    = in_acc && (cnt_q < CntW'(MAX_TASKS));
  assign n_last   = cnt_q - CntW'(1);
  assign wr_entry = '{id: in_i.task_id, arrival: in_i.arrival_time,
                      duration: in_i.duration, prio: in_i.priority_req};

  // Shared compare unit, fed by one table entry per cycle.
  assign pending  = !done_q[ridx_q];
  assign is_ready = pending && ({{(nps_pkg::TimeW - nps_pkg::ArrW){1'b0}}, rd_q.arrival} <= cur_q);
  assign take     = is_ready && (!found_q || (rd_q.prio > best_prio_q));
  assign scan_end = rvld_q && (CntW'(ridx_q) == n_last);
  assign finish   = cur_q + nps_pkg::TimeW'(best_dur_q);

  assign in_i.ready          = (state_q == S_LOAD);
  assign out_o.valid         = (state_q == S_EMIT);
  assign out_o.sched_task_id = out_id_q;
  assign out_o.start_time    = out_start_q;
  assign out_o.finish_time   = out_finish_q;
  assign out_o.wait_time     = out_wait_q;
  assign out_o.last_result   = out_last_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IdxW-1:0]] <= wr_entry;
    end
    rd_q <= mem[scan_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      cnt_q        <= '0;
      emit_q       <= '0;
      scan_q       <= '0;
      issue_q      <= 1'b0;
      rvld_q       <= 1'b0;
      ridx_q       <= '0;
      done_q       <= '0;
      cur_q        <= '0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_id_q    <= '0;
      best_arr_q   <= '0;
      best_dur_q   <= '0;
      best_prio_q  <= '0;
      earliest_q   <= '1;
      out_id_q     <= '0;
      out_start_q  <= '0;
      out_finish_q <= '0;
      out_wait_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      rvld_q <= (state_q == S_SCAN) && issue_q;
      ridx_q <= scan_q[IdxW-1:0];
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (wr_en) begin
              cnt_q <= cnt_q + CntW'(1);
            end
            if (in_i.last_task) begin
              state_q    <= S_SCAN;
              cur_q      <= '0;
              emit_q     <= '0;
              scan_q     <= '0;
              issue_q    <= 1'b1;
              found_q    <= 1'b0;
              earliest_q <= '1;
            end
          end
        end
        S_SCAN: begin
          if (issue_q) begin
            scan_q <= scan_q + CntW'(1);
            if (scan_q == n_last) begin
              issue_q <= 1'b0;
            end
          end
          if (rvld_q) begin
            if (take) begin
              found_q     <= 1'b1;
              best_idx_q  <= ridx_q;
              best_id_q   <= rd_q.id;
              best_arr_q  <= rd_q.arrival;
              best_dur_q  <= rd_q.duration;
              best_prio_q <= rd_q.prio;
            end
            if (pending && (rd_q.arrival < earliest_q)) begin
              earliest_q <= rd_q.arrival;
            end
          end
          if (scan_end) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (found_q) begin
            out_id_q           <= best_id_q;
            out_start_q        <= cur_q;
            out_finish_q       <= finish;
            out_wait_q         <= cur_q - nps_pkg::TimeW'(best_arr_q);
            out_last_q         <= (emit_q + CntW'(1) == cnt_q);
            done_q[best_idx_q] <= 1'b1;
            cur_q              <= finish;
            emit_q             <= emit_q + CntW'(1);
            state_q            <= S_EMIT;
          end else begin
            // Nothing has arrived yet: jump to the earliest pending arrival and rescan.
            cur_q      <= nps_pkg::TimeW'(earliest_q);
            state_q    <= S_SCAN;
            scan_q     <= '0;
            issue_q    <= 1'b1;
            earliest_q <= '1;
          end
        end
        S_EMIT: begin
          if (out_o.ready) begin
            if (out_last_q) begin
              state_q <= S_LOAD;
              done_q  <= '0;
              cnt_q   <= '0;
              emit_q  <= '0;
            end else begin
              state_q    <= S_SCAN;
              scan_q     <= '0;
              issue_q    <= 1'b1;
              found_q    <= 1'b0;
              earliest_q <= '1;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("load accepted while a result is pending");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_TASKS))
    else $error("load count exceeds table depth");

  a_done_matches_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(done_q) == int'(emit_q))
    else $error("done flags disagree with the number of scheduled tasks");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (emit_q <= cnt_q) && (out_o.finish_time >= out_o.start_time))
    else $error("result beyond the loaded set or finish before start");

  a_back_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.last_result |=> in_i.ready && (cnt_q == '0))
    else $error("set not closed after its last result");

endmodule

@@ tb/sv/nonpreemptive_priority_scheduler_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the non-preemptive priority scheduler: directed sets, then random.
// Depends on nps_pkg, the channel interfaces in nps_if.sv and the scheduler RTL.
module nonpreemptive_priority_scheduler_test;

  localparam int unsigned DrainCycles = 64;
  localparam int unsigned RandLoads   = 380;

  typedef struct packed {
    logic [nps_pkg::IdW-1:0]   task_id;
    logic [nps_pkg::ArrW-1:0]  arrival;
    logic [nps_pkg::DurW-1:0]  duration;
    logic [nps_pkg::PrioW-1:0] prio;
    logic                      last;
  } load_t;

  typedef struct packed {
    logic [nps_pkg::IdW-1:0]   task_id;
    logic [nps_pkg::TimeW-1:0] start;
    logic [nps_pkg::TimeW-1:0] finish;
    logic [nps_pkg::TimeW-1:0] waited;
    logic                      last;
  } slot_t;

  typedef struct {
    load_t ld;
    bit    typed;
    slot_t slot;
  } row_t;

  logic clk_i;
  logic rst_ni;

  nps_in_if  in_ch ();
  nps_out_if out_ch ();

  nonpreemptive_priority_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Shadow of the task table and the schedule slots still owed by the block.
  nps_pkg::entry_t task_tab [nps_pkg::MaxTasksDef];
  int              loaded_n;
  slot_t           expected_slots [$];

  row_t   cur_row;
  int     idle_pct;
  bit     quiet;
  int     hold_n;
  int     err_cnt;
  int     loads_taken;
  int     loads_dropped;
  int     batches_run;
  int     slots_checked;
  slot_t  got_slot;
  slot_t  want_slot;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic load_t mk_load(input logic [nps_pkg::IdW-1:0] id,
                                    input logic [nps_pkg::ArrW-1:0] arr,
                                    input logic [nps_pkg::DurW-1:0] dur,
                                    input logic [nps_pkg::PrioW-1:0] pr,
                                    input logic last);
    load_t ld;
    ld = '{id, arr, dur, pr, last};
    return ld;
  endfunction

  // Best arrived pending task; the strict compare keeps the earlier entry on a tie.
  function automatic int pick_ready(input logic [nps_pkg::TimeW-1:0] now,
                                    input logic [nps_pkg::MaxTasksDef-1:0] done);
    int best;
    best = -1;
    for (int i = 0; i < loaded_n; i++) begin
      if (done[i] || nps_pkg::TimeW'(task_tab[i].arrival) > now) continue;
      if (best < 0 || task_tab[i].prio > task_tab[best].prio) best = i;
    end
    return best;
  endfunction

  task automatic absorb_load(input load_t ld, input bit typed, input slot_t typed_slot);
    logic [nps_pkg::TimeW-1:0]       now;
    logic [nps_pkg::TimeW-1:0]       earliest;
    logic [nps_pkg::MaxTasksDef-1:0] done;
    slot_t                           s;
    int                              sel;
    if (loaded_n < nps_pkg::MaxTasksDef) begin
      task_tab[loaded_n] = '{ld.task_id, ld.arrival, ld.duration, ld.prio};
      loaded_n++;
    end else begin
      loads_dropped++;
    end
    if (!ld.last) return;
    batches_run++;
    now  = '0;
    done = '0;
    for (int k = 0; k < loaded_n; k++) begin
      sel = pick_ready(now, done);
      if (sel < 0) begin
        // Nothing has arrived yet: jump to the earliest pending arrival.
        earliest = '1;
        for (int i = 0; i < loaded_n; i++)
          if (!done[i] && nps_pkg::TimeW'(task_tab[i].arrival) < earliest)
            earliest = nps_pkg::TimeW'(task_tab[i].arrival);
        now = earliest;
        sel = pick_ready(now, done);
      end
      s.task_id = task_tab[sel].id;
      s.start   = now;
      s.finish  = now + nps_pkg::TimeW'(task_tab[sel].duration);
      s.waited  = now - nps_pkg::TimeW'(task_tab[sel].arrival);
      s.last    = (k + 1 == loaded_n);
      if (!typed) expected_slots.push_back(s);
      done[sel] = 1'b1;
      now       = s.finish;
    end
    if (typed) expected_slots.push_back(typed_slot);
    loaded_n = 0;
  endtask

  // Drives one load beat, with an optional idle burst ahead of it.
  task automatic send_load(input row_t r);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < idle_pct) gap = $urandom_range(4, 1);
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    cur_row               = r;
    in_ch.valid          <= 1'b1;
    in_ch.task_id        <= r.ld.task_id;
    in_ch.arrival_time   <= r.ld.arrival;
    in_ch.duration       <= r.ld.duration;
    in_ch.priority_req   <= r.ld.prio;
    in_ch.last_task      <= r.ld.last;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Input beats feed the predictor before the result side is checked.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      loads_taken++;
      absorb_load(mk_load(in_ch.task_id, in_ch.arrival_time, in_ch.duration,
                          in_ch.priority_req, in_ch.last_task),
                  cur_row.typed, cur_row.slot);
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got_slot = '{out_ch.sched_task_id, out_ch.start_time, out_ch.finish_time,
                   out_ch.wait_time, out_ch.last_result};
      if (expected_slots.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %p", $time, got_slot);
        err_cnt++;
      end else begin
        want_slot = expected_slots.pop_front();
        slots_checked++;
        if (got_slot.task_id !== want_slot.task_id) begin
          $display("%0t: sched_task_id expected %0d got %0d", $time,
                   want_slot.task_id, got_slot.task_id);
          err_cnt++;
        end
        if (got_slot.start !== want_slot.start) begin
          $display("%0t: start_time expected %0d got %0d", $time,
                   want_slot.start, got_slot.start);
          err_cnt++;
        end
        if (got_slot.finish !== want_slot.finish) begin
          $display("%0t: finish_time expected %0d got %0d", $time,
                   want_slot.finish, got_slot.finish);
          err_cnt++;
        end
        if (got_slot.waited !== want_slot.waited) begin
          $display("%0t: wait_time expected %0d got %0d", $time,
                   want_slot.waited, got_slot.waited);
          err_cnt++;
        end
        if (got_slot.last !== want_slot.last) begin
          $display("%0t: last_result expected %0d got %0d", $time,
                   want_slot.last, got_slot.last);
          err_cnt++;
        end
      end
    end
  end

  // Result side back-pressure in random bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_n > 0) begin
      out_ch.ready <= 1'b0;
      hold_n--;
    end else if (!quiet && $urandom_range(99) < idle_pct) begin
      out_ch.ready <= 1'b0;
      hold_n = $urandom_range(3, 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    #20_000_000;
    $display("nonpreemptive_priority_scheduler_test: errors");
    $finish;
  end

  initial begin
    row_t                       rows [$];
    row_t                       r;
    int                         stored;
    int                         n;
    int                         mode;
    int                         prio_span;
    int                         dur_span;
    logic [nps_pkg::ArrW-1:0]   base;
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.task_id       = '0;
    in_ch.arrival_time  = '0;
    in_ch.duration      = '0;
    in_ch.priority_req  = '0;
    in_ch.last_task     = 1'b0;
    idle_pct            = 20;
    quiet               = 1'b0;
    cur_row             = '{'0, 1'b0, '0};

    // Single-task sets: all-zero fields, all-ones fields, and a start delayed to its arrival.
    rows.push_back('{mk_load(8'h00, 16'd0, 12'd0, 4'd0, 1'b1), 1'b1,
                     '{8'h00, 20'd0, 20'd0, 20'd0, 1'b1}});
    rows.push_back('{mk_load(8'hFF, 16'hFFFF, 12'hFFF, 4'hF, 1'b1), 1'b1,
                     '{8'hFF, 20'd65535, 20'd69630, 20'd0, 1'b1}});
    rows.push_back('{mk_load(8'h5A, 16'd1000, 12'd7, 4'd3, 1'b1), 1'b1,
                     '{8'h5A, 20'd1000, 20'd1007, 20'd0, 1'b1}});
    // Priority order, a three-way tie and a zero-duration task.
    rows.push_back('{mk_load(8'd1, 16'd0, 12'd10, 4'd2, 1'b0), 1'b0, '0});
    rows.push_back('{mk_load(8'd2, 16'd0, 12'd5, 4'd9, 1'b0), 1'b0, '0});
    rows.push_back('{mk_load(8'd3, 16'd3, 12'd4, 4'd9, 1'b0), 1'b0, '0});
    rows.push_back('{mk_load(8'd4, 16'd0, 12'd0, 4'd9, 1'b1), 1'b0, '0});
    // Fill the table; the closing beat is dropped but still starts the schedule.
    for (int i = 0; i < nps_pkg::MaxTasksDef; i++)
      rows.push_back('{mk_load(nps_pkg::IdW'(8'hF0 + i), nps_pkg::ArrW'(i * 9),
                               nps_pkg::DurW'(i % 5), nps_pkg::PrioW'(i % 4), 1'b0),
                       1'b0, '0});
    rows.push_back('{mk_load(8'h77, 16'd2, 12'd3, 4'hF, 1'b1), 1'b0, '0});

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_load(rows[i]);
    // Let the block go fully idle before the random sets.
    drain_results();

    stored = 0;
    r.typed = 1'b0;
    r.slot  = '0;
    while (stored < RandLoads) begin
      // Mostly well-formed sets; about one in eight overruns the table.
      n         = ($urandom_range(7) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
      mode      = $urandom_range(2);
      prio_span = ($urandom_range(3) == 0) ? 1 : 15;
      dur_span  = ($urandom_range(4) == 0) ? 4095 : 40;
      base      = nps_pkg::ArrW'($urandom_range(63535));
      quiet     = (stored >= RandLoads - 50);
      case ($urandom_range(3))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        2:       idle_pct = 30;
        default: idle_pct = 60;
      endcase
      for (int j = 0; j < n; j++) begin
        r.ld.task_id = nps_pkg::IdW'($urandom_range(255));
        case (mode)
          0:       r.ld.arrival = nps_pkg::ArrW'($urandom_range(63));
          1:       r.ld.arrival = nps_pkg::ArrW'($urandom_range(65535));
          default: r.ld.arrival = base + nps_pkg::ArrW'($urandom_range(2000));
        endcase
        r.ld.duration = nps_pkg::DurW'($urandom_range(dur_span));
        r.ld.prio     = nps_pkg::PrioW'($urandom_range(prio_span));
        r.ld.last     = (j == n - 1);
        send_load(r);
        if (j < nps_pkg::MaxTasksDef) stored++;
      end
    end

    drain_results();
    $display("Took %0d load beats in %0d task sets (%0d dropped on a full table).",
             loads_taken, batches_run, loads_dropped);
    $display("Checked %0d schedule slots against the predicted run order.", slots_checked);
    if (err_cnt == 0) begin
      $display("nonpreemptive_priority_scheduler_test: clean");
    end else begin
      $display("nonpreemptive_priority_scheduler_test: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/nps_pkg.sv
hdl/nps_if.sv
hdl/nonpreemptive_priority_scheduler.sv
tb/sv/nonpreemptive_priority_scheduler_test.sv
